// ===== src/shp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_pkg
// Shared widths, register indexes and helpers for the 3x3 sharpen core.
// ----------------------------------------------------------------------------
package shp_pkg;

  // Frame geometry limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Field widths fixed by the interface
  localparam int PIX_W     = 8;
  localparam int DIM_W     = 11;
  localparam int GAIN_W    = 8;
  localparam int CFG_IDX_W = 2;

  // Derived widths
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W     = DIM_W;
  localparam int COUNT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int DIV_CNT_W = $clog2(COUNT_W + 1);
  localparam int SUM_W     = PIX_W + 5;
  localparam int PROD_W    = SUM_W + GAIN_W + 1;
  localparam int LINE_W    = 2 * PIX_W;

  // Output queue
  localparam int FIFO_DEPTH = 4;
  localparam int FQ_AW      = $clog2(FIFO_DEPTH);
  localparam int FQ_CNT_W   = $clog2(FIFO_DEPTH + 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 2'd2;

  // Reset values of the registers
  localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = DIM_W'(MAX_HEIGHT);
  localparam logic [GAIN_W-1:0] RST_GAIN         = GAIN_W'(1);

  // Per-transaction context carried alongside the line store read
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  v;
    logic              emit;
    logic              left;
    logic              right;
    logic              top;
    logic              bottom;
    logic              last;
  } stage_t;

  // Zero acts as one, anything above the limit acts as the limit
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

  // Increment that sticks at all ones
  function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r);
    logic [ROW_W-1:0] n;
    n = (r == '1) ? r : r + 1'b1;
    return n;
  endfunction

endpackage

// ===== src/shp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module shp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sharpen_3x3_scaled_clamp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sharpen_3x3_scaled_clamp_core
// 3x3 sharpen (nine times centre minus neighbours) with gain and clamp.
// ----------------------------------------------------------------------------
// Usage:
//   Input samples arrive in raster order on in_valid/in_stall with sample and
//   pad. After each frame the sender supplies frame_width+1 pad transactions
//   to flush the last rows. Results leave on out_valid/out_stall with
//   pixel_out and frame_end; frame_end marks the last pixel of the frame.
//   The result for pixel k is produced by input transaction k+frame_width+1
//   and is offered once it has passed the read stage, the kernel sum register
//   and the output queue. Throughput is one transaction per cycle while
//   in_stall is low: the two line stores sit in one RAM read once and written
//   once per transaction, with forwarding when back-to-back transactions hit
//   the same column. A four-entry output queue decouples the sides; in_stall
//   rises when the queue plus the two results in flight would overflow, so a
//   stalled receiver holds the input back after a few transactions.
//   After reset all 1024 entries of the line store RAM are cleared, during
//   which in_stall is high. A write to frame_width recomputes the output
//   position from out_count by a serial division, with in_stall high
//   meanwhile. Registers are written through cfg_write/cfg_index/cfg_data.
// ----------------------------------------------------------------------------
module sharpen_3x3_scaled_clamp_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [shp_pkg::PIX_W-1:0]      sample,
  input  logic                           pad,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [shp_pkg::PIX_W-1:0]      pixel_out,
  output logic                           frame_end,
  input  logic                           cfg_write,
  input  logic [shp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [shp_pkg::DIM_W-1:0]      cfg_data
);

  // Configuration registers
  logic [shp_pkg::DIM_W-1:0]  frame_width;
  logic [shp_pkg::DIM_W-1:0]  frame_height;
  logic [shp_pkg::GAIN_W-1:0] gain;

  // Position state
  logic [shp_pkg::ADDR_W-1:0]  in_column;
  logic [shp_pkg::ROW_W-1:0]   in_row;
  logic [shp_pkg::COUNT_W-1:0] out_count;
  logic [shp_pkg::ADDR_W-1:0]  ox;
  logic [shp_pkg::COUNT_W-1:0] oy;

  // Accept-side decode
  logic                          acc;
  logic [shp_pkg::DIM_W-1:0]     wc;
  logic [shp_pkg::DIM_W-1:0]     hc;
  logic                          col_wrap;
  logic [shp_pkg::ADDR_W-1:0]    c0;
  logic [shp_pkg::ROW_W-1:0]     row0;
  logic [shp_pkg::DIM_W-1:0]     c1;
  logic                          col_wrap2;
  logic [shp_pkg::ADDR_W-1:0]    col_next;
  logic [shp_pkg::ROW_W-1:0]     row_next;
  logic [shp_pkg::PIX_W-1:0]     v_in;
  logic                          emit;
  logic [2*shp_pkg::DIM_W-1:0]   frame_size;
  logic [shp_pkg::COUNT_W:0]     cnt_inc;
  logic                          last;
  logic                          ox_last;
  logic [shp_pkg::ADDR_W-1:0]    ox_next;
  logic [shp_pkg::COUNT_W-1:0]   oy_next;
  logic                          bottom;

  // Read stage
  logic                          s1_valid;
  shp_pkg::stage_t               s1;
  logic                          fwd;
  logic [shp_pkg::LINE_W-1:0]    fwd_data;
  logic [shp_pkg::LINE_W-1:0]    rd_data;
  logic [shp_pkg::PIX_W-1:0]     u1;
  logic [shp_pkg::PIX_W-1:0]     m1;
  logic [shp_pkg::PIX_W-1:0]     win [9];
  logic signed [shp_pkg::SUM_W-1:0] sum1;

  // RAM ports
  logic                          ram_we;
  logic [shp_pkg::ADDR_W-1:0]    ram_waddr;
  logic [shp_pkg::LINE_W-1:0]    ram_wdata;

  // Clearing pass
  logic                          clr_busy;
  logic [shp_pkg::ADDR_W-1:0]    clr_addr;

  // Serial divider for output position
  logic                          div_busy;
  logic [shp_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [shp_pkg::DIM_W-1:0]     div_rem;
  logic [shp_pkg::COUNT_W-1:0]   div_q;
  logic [shp_pkg::DIM_W:0]       rem_sh;
  logic                          rem_ge;
  logic [shp_pkg::DIM_W-1:0]     rem_next;
  logic [shp_pkg::COUNT_W-1:0]   q_next;

  // Scale stage
  logic                          s2_valid;
  logic signed [shp_pkg::SUM_W-1:0]  s2_sum;
  logic                          s2_end;
  logic signed [shp_pkg::PROD_W-1:0] prod;
  logic [shp_pkg::PIX_W-1:0]     pix2;

  // Output queue
  logic [shp_pkg::PIX_W-1:0]     fq_pix [shp_pkg::FIFO_DEPTH];
  logic                          fq_end [shp_pkg::FIFO_DEPTH];
  logic [shp_pkg::FQ_AW-1:0]     fq_wr;
  logic [shp_pkg::FQ_AW-1:0]     fq_rd;
  logic [shp_pkg::FQ_CNT_W-1:0]  fq_count;
  logic [shp_pkg::FQ_CNT_W:0]    fq_load;
  logic                          room;
  logic                          pop;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= shp_pkg::RST_FRAME_WIDTH;
      frame_height <= shp_pkg::RST_FRAME_HEIGHT;
      gain         <= shp_pkg::RST_GAIN;
    end else if (cfg_write) begin
      unique case (cfg_index)
        shp_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        shp_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        shp_pkg::REG_GAIN:         gain         <= cfg_data[shp_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Admit a transaction only with room downstream and no background work
  always_comb begin
    fq_load  = (shp_pkg::FQ_CNT_W+1)'(fq_count)
             + (shp_pkg::FQ_CNT_W+1)'(s1_valid && s1.emit)
             + (shp_pkg::FQ_CNT_W+1)'(s2_valid);
    room     = fq_load < (shp_pkg::FQ_CNT_W+1)'(shp_pkg::FIFO_DEPTH);
    in_stall = clr_busy || div_busy || !room;
    acc      = in_valid && !in_stall;
  end

  // Decode column, row and output position of the incoming transaction
  always_comb begin
    wc = shp_pkg::clamp_dim(frame_width, shp_pkg::DIM_W'(shp_pkg::MAX_WIDTH));
    hc = shp_pkg::clamp_dim(frame_height, shp_pkg::DIM_W'(shp_pkg::MAX_HEIGHT));

    col_wrap = shp_pkg::DIM_W'(in_column) >= wc;
    c0       = col_wrap ? '0 : in_column;
    row0     = col_wrap ? shp_pkg::row_inc(in_row) : in_row;

    v_in = (pad || (shp_pkg::DIM_W'(row0) >= hc)) ? '0 : sample;
    emit = (row0 >= shp_pkg::ROW_W'(2)) || ((row0 == shp_pkg::ROW_W'(1)) && (c0 != '0));

    c1        = shp_pkg::DIM_W'(c0) + 1'b1;
    col_wrap2 = c1 >= wc;
    col_next  = col_wrap2 ? '0 : c1[shp_pkg::ADDR_W-1:0];
    row_next  = col_wrap2 ? shp_pkg::row_inc(row0) : row0;

    frame_size = wc * hc;
    cnt_inc    = (shp_pkg::COUNT_W+1)'(out_count) + 1'b1;
    last       = (2*shp_pkg::DIM_W)'(cnt_inc) >= frame_size;

    ox_last = shp_pkg::DIM_W'(ox) == (wc - 1'b1);
    ox_next = ox_last ? '0 : ox + 1'b1;
    oy_next = ox_last ? oy + 1'b1 : oy;
    bottom  = ((shp_pkg::COUNT_W+1)'(oy) + 1'b1) >= (shp_pkg::COUNT_W+1)'(hc);
  end

  // Serial restoring division step: output position from out_count
  always_comb begin
    rem_sh   = {div_rem, div_q[shp_pkg::COUNT_W-1]};
    rem_ge   = rem_sh >= (shp_pkg::DIM_W+1)'(wc);
    rem_next = rem_ge ? shp_pkg::DIM_W'(rem_sh - (shp_pkg::DIM_W+1)'(wc))
                      : rem_sh[shp_pkg::DIM_W-1:0];
    q_next   = {div_q[shp_pkg::COUNT_W-2:0], rem_ge};
  end

  // Run the divider after a width change
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (cfg_write && (cfg_index == shp_pkg::REG_FRAME_WIDTH)) begin
      div_busy <= 1'b1;
      div_cnt  <= shp_pkg::DIV_CNT_W'(shp_pkg::COUNT_W);
    end else if (div_busy) begin
      div_cnt <= div_cnt - 1'b1;
      if (div_cnt == shp_pkg::DIV_CNT_W'(1)) begin
        div_busy <= 1'b0;
      end
    end
  end

  // Divider datapath
  always_ff @(posedge clk) begin
    if (cfg_write && (cfg_index == shp_pkg::REG_FRAME_WIDTH)) begin
      div_rem <= '0;
      div_q   <= out_count;
    end else if (div_busy) begin
      div_rem <= rem_next;
      div_q   <= q_next;
    end
  end

  // Advance input and output positions
  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
      out_count <= '0;
      ox        <= '0;
      oy        <= '0;
    end else if (acc) begin
      if (emit && last) begin
        in_column <= '0;
        in_row    <= '0;
        out_count <= '0;
        ox        <= '0;
        oy        <= '0;
      end else begin
        in_column <= col_next;
        in_row    <= row_next;
        if (emit) begin
          out_count <= cnt_inc[shp_pkg::COUNT_W-1:0];
          ox        <= ox_next;
          oy        <= oy_next;
        end
      end
    end else if (div_busy && (div_cnt == shp_pkg::DIV_CNT_W'(1))) begin
      ox <= rem_next[shp_pkg::ADDR_W-1:0];
      oy <= q_next;
    end
  end

  // Clear the line store after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == shp_pkg::ADDR_W'(shp_pkg::MAX_WIDTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // Hold the transaction context while the line store read is in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd      <= 1'b0;
    end else begin
      s1_valid <= acc;
      fwd      <= acc && s1_valid && (c0 == s1.addr);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1.addr   <= c0;
      s1.v      <= v_in;
      s1.emit   <= emit;
      s1.left   <= ox == '0;
      s1.right  <= ox_last;
      s1.top    <= oy == '0;
      s1.bottom <= bottom;
      s1.last   <= last;
      fwd_data  <= ram_wdata;
    end
  end

  // Line store RAM: upper row in the high byte, middle row in the low byte
  always_comb begin
    u1 = fwd ? fwd_data[shp_pkg::LINE_W-1:shp_pkg::PIX_W] : rd_data[shp_pkg::LINE_W-1:shp_pkg::PIX_W];
    m1 = fwd ? fwd_data[shp_pkg::PIX_W-1:0] : rd_data[shp_pkg::PIX_W-1:0];
    if (clr_busy) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_valid;
      ram_waddr = s1.addr;
      ram_wdata = {m1, s1.v};
    end
  end

  shp_ram #(
    .WIDTH (shp_pkg::LINE_W),
    .DEPTH (shp_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (c0),
    .rdata (rd_data)
  );

  // Shift the 3x3 window
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3]   <= win[r*3+1];
        win[r*3+1] <= win[r*3+2];
      end
      win[2] <= u1;
      win[5] <= m1;
      win[8] <= s1.v;
    end
  end

  // Kernel sum with frame border masking
  always_comb begin
    logic [shp_pkg::PIX_W-1:0]  l0, l1, l2, t1, b1, r0, r1, r2, cm;
    logic [shp_pkg::PIX_W+3:0]  pos;
    logic [shp_pkg::PIX_W+2:0]  neg;
    // left column is the old middle, centre the old right, right the new data
    l0 = win[1];
    l1 = win[4];
    l2 = win[7];
    t1 = win[2];
    cm = win[5];
    b1 = win[8];
    r0 = s1.right ? '0 : u1;
    r1 = s1.right ? '0 : m1;
    r2 = s1.right ? '0 : s1.v;
    if (s1.left) begin
      l0 = '0;
      l1 = '0;
      l2 = '0;
    end
    if (s1.top) begin
      l0 = '0;
      t1 = '0;
      r0 = '0;
    end
    if (s1.bottom) begin
      l2 = '0;
      b1 = '0;
      r2 = '0;
    end
    pos  = {1'b0, cm, 3'b000} + (shp_pkg::PIX_W+4)'(cm);
    neg  = (shp_pkg::PIX_W+3)'(l0) + (shp_pkg::PIX_W+3)'(l1) + (shp_pkg::PIX_W+3)'(l2)
         + (shp_pkg::PIX_W+3)'(t1) + (shp_pkg::PIX_W+3)'(b1)
         + (shp_pkg::PIX_W+3)'(r0) + (shp_pkg::PIX_W+3)'(r1) + (shp_pkg::PIX_W+3)'(r2);
    sum1 = $signed({1'b0, pos}) - $signed({2'b00, neg});
  end

  // Register the kernel sum
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1.emit) begin
      s2_sum <= sum1;
      s2_end <= s1.last;
    end
  end

  // Scale by gain and clamp to the pixel range
  always_comb begin
    prod = s2_sum * $signed({1'b0, gain});
    if (prod < 0) begin
      pix2 = '0;
    end else if (prod > shp_pkg::PROD_W'(255)) begin
      pix2 = '1;
    end else begin
      pix2 = prod[shp_pkg::PIX_W-1:0];
    end
  end

  // Output queue
  assign pop       = out_valid && !out_stall;
  assign out_valid = fq_count != '0;
  assign pixel_out = fq_pix[fq_rd];
  assign frame_end = fq_end[fq_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      fq_wr    <= '0;
      fq_rd    <= '0;
      fq_count <= '0;
    end else begin
      if (s2_valid) begin
        fq_wr <= fq_wr + 1'b1;
      end
      if (pop) begin
        fq_rd <= fq_rd + 1'b1;
      end
      fq_count <= fq_count + shp_pkg::FQ_CNT_W'(s2_valid) - shp_pkg::FQ_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      fq_pix[fq_wr] <= pix2;
      fq_end[fq_wr] <= s2_end;
    end
  end

endmodule
